### rtl/core/vmc_pkg.sv
// vmc_pkg: widths, codes, command/status types and the side clamp shared by
// the mask centroid controller, datapath, divider and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vmc_pkg;

  // largest volume side in voxels; internal widths follow from it
  localparam int MAX_SIDE = 1024;

  localparam int POS_W   = $clog2(MAX_SIDE);
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int CMP_W   = POS_W + 1;
  localparam int CNT_W   = 3 * POS_W + 1;
  localparam int SUM_W   = 4 * POS_W;
  localparam int FRAC_W  = 16;
  localparam int CFRAC_W = 8;
  localparam int Q_W     = POS_W + FRAC_W;
  localparam int NUM_W   = SUM_W + FRAC_W;
  localparam int DIV_W   = CNT_W + POS_W;
  localparam int QCNT_W  = $clog2(Q_W);

  // fixed field widths
  localparam int CFG_W  = 11;
  localparam int VOX_W  = 8;
  localparam int CEN_W  = 18;
  localparam int REL_W  = 16;
  localparam int ICNT_W = 31;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd256;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       step;      // voxel accepted
    logic       load_div;  // start one division
    logic       capture;   // store finished quotient
    logic       emit;      // load output register, clear volume state
    logic       rel;       // relative (Q0.16) division, else centroid
    logic [1:0] axis;
  } vmc_cmd_t;

  typedef struct packed {
    logic last_pos;
    logic count_zero;
    logic div_busy;
    logic out_free;
  } vmc_stat_t;

  // zero reads as one, anything above MAX_SIDE saturates
  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (r == '0) begin
      s = SIDE_W'(1);
    end else if (32'(r) > 32'(MAX_SIDE)) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(r);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/volume_mask_centroid.sv
// Accepts 8-bit mask voxels in raster order (x fastest, then y, then z), one
// per clock while a volume is streaming; each nonzero voxel adds its position
// to three coordinate sums and bumps a hit count. After the last voxel of the
// size_x * size_y * size_z volume the block stalls its input while one shared
// restoring divider, one quotient bit per cycle, works out three Q10.8
// centroids and three Q0.16 relative centroids (an empty volume skips the
// divisions), and then waits, if need be, for the output register to free up.
// Results go out through a registered stage, so intake of the next volume
// resumes while the previous result is still waiting. Size registers sit at
// byte addresses 0, 4 and 8 of the APB port; a size of zero counts as one,
// and sizes above the maximum side saturate.
// Depends on vmc_pkg, vmc_ctrl, vmc_dp (and vmc_div below it).
`timescale 1ns / 1ps
`default_nettype none

module volume_mask_centroid (
  input  wire                          clk,
  input  wire                          rst_n,
  // voxel stream
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [vmc_pkg::VOX_W-1:0]     in_voxel_value,
  // result stream
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_x,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_y,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_z,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_x,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_y,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_z,
  output logic [vmc_pkg::ICNT_W-1:0]   out_inside_count,
  output logic                         out_empty_mask,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [vmc_pkg::APB_AW-1:0]    paddr,
  input  wire [vmc_pkg::APB_DW-1:0]    pwdata,
  output logic [vmc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  logic [vmc_pkg::CFG_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [vmc_pkg::SIDE_W-1:0] side_x, side_y, side_z;
  logic [1:0]                 reg_idx;
  logic                       cfg_wr;

  vmc_pkg::vmc_cmd_t  cmd;
  vmc_pkg::vmc_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= vmc_pkg::SIZE_RESET;
      size_y_r <= vmc_pkg::SIZE_RESET;
      size_z_r <= vmc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        vmc_pkg::REG_SIZE_X: size_x_r <= pwdata[vmc_pkg::CFG_W-1:0];
        vmc_pkg::REG_SIZE_Y: size_y_r <= pwdata[vmc_pkg::CFG_W-1:0];
        vmc_pkg::REG_SIZE_Z: size_z_r <= pwdata[vmc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      vmc_pkg::REG_SIZE_X: prdata = vmc_pkg::APB_DW'(size_x_r);
      vmc_pkg::REG_SIZE_Y: prdata = vmc_pkg::APB_DW'(size_y_r);
      vmc_pkg::REG_SIZE_Z: prdata = vmc_pkg::APB_DW'(size_z_r);
      default:             prdata = '0;
    endcase
  end

  assign side_x = vmc_pkg::eff_side(size_x_r);
  assign side_y = vmc_pkg::eff_side(size_y_r);
  assign side_z = vmc_pkg::eff_side(size_z_r);

  vmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vmc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_voxel_value   (in_voxel_value),
    .side_x           (side_x),
    .side_y           (side_y),
    .side_z           (side_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y),
    .out_centroid_z   (out_centroid_z),
    .out_relative_x   (out_relative_x),
    .out_relative_y   (out_relative_y),
    .out_relative_z   (out_relative_z),
    .out_inside_count (out_inside_count),
    .out_empty_mask   (out_empty_mask)
  );

endmodule

`default_nettype wire

### rtl/core/vmc_div.sv
// vmc_div: restoring divider, one quotient bit per cycle.
// Depends on vmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmc_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       load,
  input  wire [vmc_pkg::NUM_W-1:0]  dividend,
  input  wire [vmc_pkg::DIV_W-1:0]  divisor,
  output logic                      busy,
  output logic [vmc_pkg::Q_W-1:0]   quotient
);

  logic                        busy_r;
  logic [vmc_pkg::QCNT_W-1:0]  step_r;
  logic [vmc_pkg::DIV_W-1:0]   rem_r;
  logic [vmc_pkg::Q_W-1:0]     numq_r;
  logic [vmc_pkg::DIV_W-1:0]   dvs_r;

  logic [vmc_pkg::DIV_W:0]     trial;
  logic                        ge;
  logic [vmc_pkg::DIV_W:0]     diff;

  assign trial = {rem_r, numq_r[vmc_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == vmc_pkg::QCNT_W'(vmc_pkg::Q_W - 1)) begin
        busy_r <= 1'b0;
      end
      step_r <= step_r + vmc_pkg::QCNT_W'(1);
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r  <= vmc_pkg::DIV_W'(dividend[vmc_pkg::NUM_W-1:vmc_pkg::Q_W]);
      numq_r <= dividend[vmc_pkg::Q_W-1:0];
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[vmc_pkg::DIV_W-1:0] : trial[vmc_pkg::DIV_W-1:0];
      numq_r <= {numq_r[vmc_pkg::Q_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = numq_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r) else $error("divider loaded while busy");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> busy_r && step_r == '0) else $error("divider did not start");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dvs_r) else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

### rtl/core/vmc_dp.sv
// vmc_dp: position counters, coordinate sums, hit count, divider feed,
// quotient store and output register. Depends on vmc_pkg and vmc_div.
`timescale 1ns / 1ps
`default_nettype none

module vmc_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  vmc_pkg::vmc_cmd_t            cmd,
  output vmc_pkg::vmc_stat_t           stat,
  input  wire [vmc_pkg::VOX_W-1:0]     in_voxel_value,
  input  wire [vmc_pkg::SIDE_W-1:0]    side_x,
  input  wire [vmc_pkg::SIDE_W-1:0]    side_y,
  input  wire [vmc_pkg::SIDE_W-1:0]    side_z,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_x,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_y,
  output logic [vmc_pkg::CEN_W-1:0]    out_centroid_z,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_x,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_y,
  output logic [vmc_pkg::REL_W-1:0]    out_relative_z,
  output logic [vmc_pkg::ICNT_W-1:0]   out_inside_count,
  output logic                         out_empty_mask
);

  localparam int PROD_W = vmc_pkg::CNT_W + vmc_pkg::SIDE_W;

  logic [vmc_pkg::POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [vmc_pkg::SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [vmc_pkg::CNT_W-1:0] cnt_r;

  logic [vmc_pkg::CEN_W-1:0] cen_x_r, cen_y_r, cen_z_r;
  logic [vmc_pkg::REL_W-1:0] rel_x_r, rel_y_r, rel_z_r;

  logic                       out_valid_r;
  logic [vmc_pkg::CEN_W-1:0]  o_cen_x_r, o_cen_y_r, o_cen_z_r;
  logic [vmc_pkg::REL_W-1:0]  o_rel_x_r, o_rel_y_r, o_rel_z_r;
  logic [vmc_pkg::ICNT_W-1:0] o_cnt_r;
  logic                       o_empty_r;

  logic wrap_x, wrap_y, wrap_z;
  logic hit;
  logic out_free;
  logic count_zero;

  logic [vmc_pkg::SUM_W-1:0]  sum_sel;
  logic [vmc_pkg::SIDE_W-1:0] side_sel;
  logic [PROD_W-1:0]          prod;
  logic [vmc_pkg::DIV_W-1:0]  divisor;
  logic [vmc_pkg::NUM_W-1:0]  dividend;
  logic                       div_busy;
  logic [vmc_pkg::Q_W-1:0]    quotient;

  assign wrap_x = ({1'b0, pos_x_r} + vmc_pkg::CMP_W'(1)) >= vmc_pkg::CMP_W'(side_x);
  assign wrap_y = ({1'b0, pos_y_r} + vmc_pkg::CMP_W'(1)) >= vmc_pkg::CMP_W'(side_y);
  assign wrap_z = ({1'b0, pos_z_r} + vmc_pkg::CMP_W'(1)) >= vmc_pkg::CMP_W'(side_z);
  assign hit        = |in_voxel_value;
  assign count_zero = cnt_r == '0;
  assign out_free   = !out_valid_r || !out_stall;

  // accumulate voxels; clear once the result is handed to the output
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.step) begin
      if (hit) begin
        sum_x_r <= sum_x_r + vmc_pkg::SUM_W'(pos_x_r);
        sum_y_r <= sum_y_r + vmc_pkg::SUM_W'(pos_y_r);
        sum_z_r <= sum_z_r + vmc_pkg::SUM_W'(pos_z_r);
        cnt_r   <= cnt_r + vmc_pkg::CNT_W'(1);
      end
      if (wrap_x) begin
        pos_x_r <= '0;
        if (wrap_y) begin
          pos_y_r <= '0;
          pos_z_r <= wrap_z ? '0 : pos_z_r + vmc_pkg::POS_W'(1);
        end else begin
          pos_y_r <= pos_y_r + vmc_pkg::POS_W'(1);
        end
      end else begin
        pos_x_r <= pos_x_r + vmc_pkg::POS_W'(1);
      end
    end
  end

  always_comb begin
    case (cmd.axis)
      vmc_pkg::AXIS_X: begin
        sum_sel  = sum_x_r;
        side_sel = side_x;
      end
      vmc_pkg::AXIS_Y: begin
        sum_sel  = sum_y_r;
        side_sel = side_y;
      end
      default: begin
        sum_sel  = sum_z_r;
        side_sel = side_z;
      end
    endcase
  end

  // for a relative division count * side feeds the divisor register directly, else the count
  assign prod     = PROD_W'(cnt_r) * PROD_W'(side_sel);
  assign divisor  = cmd.rel ? prod[vmc_pkg::DIV_W-1:0] : vmc_pkg::DIV_W'(cnt_r);
  assign dividend = cmd.rel ? (vmc_pkg::NUM_W'(sum_sel) << vmc_pkg::FRAC_W)
                            : (vmc_pkg::NUM_W'(sum_sel) << vmc_pkg::CFRAC_W);

  vmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.load_div),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      case ({cmd.rel, cmd.axis})
        {1'b0, vmc_pkg::AXIS_X}: cen_x_r <= vmc_pkg::CEN_W'(quotient);
        {1'b0, vmc_pkg::AXIS_Y}: cen_y_r <= vmc_pkg::CEN_W'(quotient);
        {1'b0, vmc_pkg::AXIS_Z}: cen_z_r <= vmc_pkg::CEN_W'(quotient);
        {1'b1, vmc_pkg::AXIS_X}: rel_x_r <= vmc_pkg::REL_W'(quotient);
        {1'b1, vmc_pkg::AXIS_Y}: rel_y_r <= vmc_pkg::REL_W'(quotient);
        {1'b1, vmc_pkg::AXIS_Z}: rel_z_r <= vmc_pkg::REL_W'(quotient);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // empty volume: zero every field but the flag
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_empty_r <= count_zero;
      o_cnt_r   <= vmc_pkg::ICNT_W'(cnt_r);
      o_cen_x_r <= count_zero ? '0 : cen_x_r;
      o_cen_y_r <= count_zero ? '0 : cen_y_r;
      o_cen_z_r <= count_zero ? '0 : cen_z_r;
      o_rel_x_r <= count_zero ? '0 : rel_x_r;
      o_rel_y_r <= count_zero ? '0 : rel_y_r;
      o_rel_z_r <= count_zero ? '0 : rel_z_r;
    end
  end

  assign stat.last_pos   = wrap_x && wrap_y && wrap_z;
  assign stat.count_zero = count_zero;
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = out_free;

  assign out_valid        = out_valid_r;
  assign out_centroid_x   = o_cen_x_r;
  assign out_centroid_y   = o_cen_y_r;
  assign out_centroid_z   = o_cen_z_r;
  assign out_relative_x   = o_rel_x_r;
  assign out_relative_y   = o_rel_y_r;
  assign out_relative_z   = o_rel_z_r;
  assign out_inside_count = o_cnt_r;
  assign out_empty_mask   = o_empty_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> cnt_r == '0 && pos_x_r == '0 && pos_y_r == '0 && pos_z_r == '0
                 && out_valid_r)
    else $error("volume state not cleared on emit");

endmodule

`default_nettype wire

### rtl/core/vmc_ctrl.sv
// vmc_ctrl: sequencer for the mask centroid block: voxel intake, six
// divisions at the end of a non-empty volume, hand-off to the output register.
// Depends on vmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  vmc_pkg::vmc_stat_t  stat,
  output vmc_pkg::vmc_cmd_t   cmd
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       rel_r, rel_nxt;

  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    rel_nxt      = rel_r;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.axis     = axis_r;
    cmd.rel      = rel_r;
    case (state_r)
      ST_ACC: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.step = 1'b1;
          if (stat.last_pos) begin
            state_nxt = ST_PREP;
            axis_nxt  = vmc_pkg::AXIS_X;
            rel_nxt   = 1'b0;
          end
        end
      end
      ST_PREP: begin
        // nothing to divide for an empty volume
        if (stat.count_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.load_div = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          cmd.capture = 1'b1;
          if (axis_r == vmc_pkg::AXIS_Z) begin
            if (rel_r) begin
              state_nxt = ST_OUT;
            end else begin
              axis_nxt  = vmc_pkg::AXIS_X;
              rel_nxt   = 1'b1;
              state_nxt = ST_PREP;
            end
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      axis_r  <= vmc_pkg::AXIS_X;
      rel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      rel_r   <= rel_nxt;
    end
  end

  a_last_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && in_valid && stat.last_pos) |=> state_r == ST_PREP)
    else $error("last voxel did not start the divisions");

endmodule

`default_nettype wire
